### sv/iorb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: shared package
// Sizes, request types and the per-cell control group used by all files.
// ----------------------------------------------------------------------------
package iorb_pkg;

    localparam int WINDOW        = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int ID_WIDTH      = 16;
    localparam int IDX_WIDTH     = $clog2(WINDOW);

    // Result status codes.
    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef logic [ID_WIDTH-1:0]      t_id;
    typedef logic [PAYLOAD_WIDTH-1:0] t_payload;

    // Input request: one tagged item.
    typedef struct packed {
        t_id      sequence_id;
        t_payload payload;
    } t_in_req;

    // Output request: one released or rejected item.
    typedef struct packed {
        t_id      out_id;
        t_payload out_payload;
        logic     status;
        logic     last;
    } t_out_req;

    // Control handed from the top level to each cell.
    typedef struct packed {
        logic shift;
        logic write;
    } t_cell_ctl;

endpackage : iorb_pkg
`default_nettype wire

### sv/iorb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: input channel
// Valid/ready channel that carries one tagged item per request.
// ----------------------------------------------------------------------------
interface iorb_in_if
    import iorb_pkg::*;
();
    logic    valid;
    logic    ready;
    t_in_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface : iorb_in_if
`default_nettype wire

### sv/iorb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: output channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface iorb_out_if
    import iorb_pkg::*;
();
    logic     valid;
    logic     ready;
    t_out_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface : iorb_out_if
`default_nettype wire

### sv/iorb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: window cell
// Holds one slot of the window. On a shift it takes the contents of its
// upper neighbour; on a write it captures the incoming payload.
// ----------------------------------------------------------------------------
module iorb_cell
    import iorb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_payload  i_wr_payload,
    input  wire logic      i_nb_valid,
    input  wire t_payload  i_nb_payload,
    output logic           o_valid,
    output t_payload       o_payload
);

    logic     r_valid;
    logic     n_valid;
    t_payload r_payload;
    t_payload n_payload;

    // A write and a shift never fall in the same cycle.
    always_comb begin
        n_valid   = r_valid;
        n_payload = r_payload;
        if (i_ctl.write) begin
            n_valid   = 1'b1;
            n_payload = i_wr_payload;
        end else if (i_ctl.shift) begin
            n_valid   = i_nb_valid;
            n_payload = i_nb_payload;
        end
    end

    // Valid bit is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The payload needs no reset: it is read only while valid.
    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
    end

    assign o_valid   = r_valid;
    assign o_payload = r_payload;

endmodule : iorb_cell
`default_nettype wire

### sv/in_order_reorder_buffer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: top level
// Releases tagged items strictly in sequence order through a row of cells, and rejects ids outside the window.
// ----------------------------------------------------------------------------
// Items arrive with a sequence id in any order and leave in id order. Cell 0
// of the row always belongs to the expected id, cell k to the id k ahead. An
// item that lies ahead inside the window is written into its cell and gives
// no result. An item with the expected id is released at once; then the row
// shifts down one cell per cycle while the output side takes results, and
// every valid cell that reaches cell 0 is released in one run; no further
// item is taken until the run ends. A stale id, or one beyond the window, is
// answered with a single reject result and changes nothing. The last result
// caused by an input carries last set. A request is taken when the block is
// not draining and the output register is empty or being emptied, and its
// first result appears in the output register in the next cycle. With an
// output side that never stalls, items that arrive in order pass at one per
// cycle, while an item that was held ahead is first stored in its cell and
// later drained from cell 0 in a release run.
// ----------------------------------------------------------------------------
module in_order_reorder_buffer_top
    import iorb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iorb_in_if.sink   i_in,
    iorb_out_if.source o_out
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    localparam logic [ID_WIDTH:0] WINDOW_SPAN = (ID_WIDTH+1)'(WINDOW);

    logic      r_state;
    logic      n_state;
    t_id       r_expected;
    t_id       n_expected;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_req  r_out;
    t_out_req  n_out;

    logic      w_out_free;
    logic      w_accept;
    t_id       w_offset;
    logic      w_in_window;
    logic      w_shift;
    logic      w_store;

    logic     [WINDOW-1:0] w_valid;
    t_payload              w_payload [WINDOW];
    t_cell_ctl             w_ctl     [WINDOW];

    // Handshake on both sides.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.req   = r_out;

    // Offset of the incoming id from the expected one, modulo the id range.
    assign w_offset    = i_in.req.sequence_id - r_expected;
    assign w_in_window = {1'b0, w_offset} < WINDOW_SPAN;
    assign w_store     = w_accept && w_in_window && (w_offset != '0);

    // Sequencer: release, drain and reject decisions.
    always_comb begin
        n_state     = r_state;
        n_expected  = r_expected;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        w_shift     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_in_window) begin
                    n_out_valid       = 1'b1;
                    n_out.out_id      = i_in.req.sequence_id;
                    n_out.out_payload = i_in.req.payload;
                    n_out.status      = STATUS_REJECTED;
                    n_out.last        = 1'b1;
                end else if (w_accept && (w_offset == '0)) begin
                    n_out_valid       = 1'b1;
                    n_out.out_id      = i_in.req.sequence_id;
                    n_out.out_payload = i_in.req.payload;
                    n_out.status      = STATUS_RELEASED;
                    n_out.last        = !w_valid[1];
                    n_expected        = r_expected + 1'b1;
                    w_shift           = 1'b1;
                    if (w_valid[1]) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_id      = r_expected;
                    n_out.out_payload = w_payload[0];
                    n_out.status      = STATUS_RELEASED;
                    n_out.last        = !w_valid[1];
                    n_expected        = r_expected + 1'b1;
                    w_shift           = 1'b1;
                    if (!w_valid[1]) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_expected  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Row of window cells; cell k holds the id k ahead of the expected one.
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic     w_nb_valid;
        t_payload w_nb_payload;

        if (g == WINDOW - 1) begin : g_end
            assign w_nb_valid   = 1'b0;
            assign w_nb_payload = '0;
        end else begin : g_mid
            assign w_nb_valid   = w_valid[g+1];
            assign w_nb_payload = w_payload[g+1];
        end

        assign w_ctl[g].shift = w_shift;
        assign w_ctl[g].write = w_store && (w_offset == ID_WIDTH'(g));

        iorb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_wr_payload (i_in.req.payload),
            .i_nb_valid   (w_nb_valid),
            .i_nb_payload (w_nb_payload),
            .o_valid      (w_valid[g]),
            .o_payload    (w_payload[g])
        );
    end

`ifndef SYNTHESIS
    // The cell of the expected id is never full while new items are taken.
    a_head_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_valid[0])
        else $error("expected-id cell holds an item while idle");

    // A result without last means the run goes on.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.req.last) |-> (r_state == S_DRAIN))
        else $error("non-final result taken outside a release run");

    // Storing an item ahead does not move the expected id.
    a_store_holds_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store |=> $stable(r_expected))
        else $error("expected id moved on a stored item");

    // A reject result always ends its request.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.req.status == STATUS_REJECTED)) |-> o_out.req.last)
        else $error("reject result without last");
`endif

endmodule : in_order_reorder_buffer_top
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// In-order reorder buffer: testbench
// Sends tagged requests in scrambled order and checks the in-order releases.
// ----------------------------------------------------------------------------
// The bench predicts every result with its own copy of the expected id, the
// held flags and the held payloads. Every accepted output request is checked
// field by field against the oldest prediction.
// The stimulus runs in this order:
//   - a short table of directed rows;
//   - random runs of consecutive ids sent in shuffled order, mixed with stale,
//     stray and re-sent ids.
// Both sides idle at random. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module testbench;
    import iorb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * WINDOW + 8;
    localparam int MAX_PRINTED  = 50;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_RELEASE_ONE,
        ROW_REJECT
    } t_row_kind;

    // Kinds of stray request mixed into the random part.
    typedef enum logic [1:0] {
        STRAY_STALE,
        STRAY_ANY,
        STRAY_AHEAD
    } t_stray;

    typedef struct {
        t_id       id;
        t_payload  pay;
        t_row_kind kind;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    iorb_in_if  in_ch ();
    iorb_out_if out_ch ();

    in_order_reorder_buffer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predicted state of the buffer.
    t_id                  next_id;
    logic                 held     [WINDOW];
    t_payload             held_pay [WINDOW];
    logic [IDX_WIDTH-1:0] head_cell;

    t_out_req    awaited_releases[$];
    t_row        script[$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    bit          quiet;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_req make_result(input t_id id_v, input t_payload pay_v,
                                             input logic status_v, input logic last_v);
        t_out_req r;
        r.out_id      = id_v;
        r.out_payload = pay_v;
        r.status      = status_v;
        r.last        = last_v;
        return r;
    endfunction

    // Works out the results of one accepted request and updates the state.
    function automatic void release_in_order(input t_in_req item, ref t_out_req res[$]);
        t_id                  offset;
        logic [IDX_WIDTH-1:0] slot_idx;
        int unsigned          drained;
        res.delete();
        offset = item.sequence_id - next_id;
        if (offset >= WINDOW) begin
            res.push_back(make_result(item.sequence_id, item.payload, STATUS_REJECTED, 1'b1));
            return;
        end
        if (offset != 0) begin
            slot_idx           = head_cell + offset[IDX_WIDTH-1:0];
            held[slot_idx]     = 1'b1;
            held_pay[slot_idx] = item.payload;
            return;
        end
        res.push_back(make_result(item.sequence_id, item.payload, STATUS_RELEASED, 1'b0));
        held[head_cell] = 1'b0;
        next_id         = next_id + 1'b1;
        head_cell       = head_cell + 1'b1;
        // Drain the held cells that follow on without a gap.
        for (drained = 1; drained < WINDOW && held[head_cell]; drained++) begin
            res.push_back(make_result(next_id, held_pay[head_cell], STATUS_RELEASED, 1'b0));
            held[head_cell] = 1'b0;
            next_id         = next_id + 1'b1;
            head_cell       = head_cell + 1'b1;
        end
        res[res.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        end
    endtask

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    // Sends one request and records what it should produce.
    task automatic send_request(input t_id id_v, input t_payload pay_v, input t_row_kind kind);
        t_in_req     item;
        t_out_req    fresh[$];
        t_out_req    want;
        int unsigned gap;
        item.sequence_id = id_v;
        item.payload     = pay_v;
        gap              = draw_wait();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req   <= item;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        release_in_order(item, fresh);
        if (kind == ROW_PREDICT) begin
            foreach (fresh[k]) awaited_releases.push_back(fresh[k]);
        end else begin
            want = make_result(id_v, pay_v,
                               (kind == ROW_REJECT) ? STATUS_REJECTED : STATUS_RELEASED, 1'b1);
            if (fresh.size() != 1) begin
                report_mismatch("directed row result count", fresh.size(), 1);
            end else if (fresh[0] !== want) begin
                report_mismatch("directed row against predictor", fresh[0], want);
            end
            awaited_releases.push_back(want);
        end
        items_sent++;
    endtask

    // Holds the input back until every predicted result has come out.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_releases.size() != 0);
    endtask

    // A run of consecutive ids from the expected one, in shuffled order.
    task automatic send_window_run();
        t_id         order[$];
        t_id         base;
        t_id         tmp;
        int unsigned len;
        int unsigned j;
        base = next_id;
        len  = $urandom_range(1, WINDOW);
        for (int k = 0; k < len; k++) order.push_back(base + t_id'(k));
        for (int k = len - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        // Now and then an id ahead is sent twice; the second overwrites if still held.
        if (len > 1 && $urandom_range(0, 2) == 0) begin
            order.push_front(base + t_id'($urandom_range(1, len - 1)));
        end
        foreach (order[k]) send_request(order[k], $urandom(), ROW_PREDICT);
    endtask

    task automatic send_stray();
        t_id id_v;
        case (t_stray'($urandom_range(0, 2)))
            STRAY_STALE: id_v = next_id - t_id'($urandom_range(1, 64));
            STRAY_ANY:   id_v = t_id'($urandom());
            default:     id_v = next_id + t_id'($urandom_range(1, WINDOW - 1));
        endcase
        send_request(id_v, $urandom(), ROW_PREDICT);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned start;
        int unsigned runs;
        start = items_sent;
        runs  = 0;
        while (items_sent - start < count) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) begin
                send_window_run();
            end else begin
                send_stray();
            end
            runs++;
            if (runs == 3) wait_for_drain();
        end
        quiet = 1'b0;
    endtask

    // Output side: random stalls before each result.
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Check every accepted output request against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (awaited_releases.size() == 0) begin
                report_mismatch("result with none expected", out_ch.req, '0);
            end else begin
                want = awaited_releases.pop_front();
                if (out_ch.req.out_id !== want.out_id) begin
                    report_mismatch("out_id", out_ch.req.out_id, want.out_id);
                end
                if (out_ch.req.out_payload !== want.out_payload) begin
                    report_mismatch("out_payload", out_ch.req.out_payload, want.out_payload);
                end
                if (out_ch.req.status !== want.status) begin
                    report_mismatch("status", out_ch.req.status, want.status);
                end
                if (out_ch.req.last !== want.last) begin
                    report_mismatch("last", out_ch.req.last, want.last);
                end
            end
        end
    end

    // Watchdog: ends the run when no request moves for too long.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.req      = '0;
        next_id        = '0;
        head_cell      = '0;
        mismatch_count = 0;
        items_sent     = 0;
        quiet          = 1'b0;
        for (int k = 0; k < WINDOW; k++) begin
            held[k]     = 1'b0;
            held_pay[k] = '0;
        end

        // Directed table: extremes, stale and far ids, overwrite, full drain.
        script.push_back('{16'h0000, 32'hFFFF_FFFF, ROW_RELEASE_ONE});
        script.push_back('{16'hFFFF, 32'h0000_0000, ROW_REJECT});
        script.push_back('{16'h0000, 32'h1234_5678, ROW_REJECT});
        script.push_back('{16'h0011, 32'hA5A5_A5A5, ROW_REJECT});
        script.push_back('{16'h0010, 32'h5A5A_5A5A, ROW_PREDICT});
        script.push_back('{16'h0003, 32'h0000_0003, ROW_PREDICT});
        script.push_back('{16'h0003, 32'hC003_C003, ROW_PREDICT});
        script.push_back('{16'h0002, 32'h8000_0002, ROW_PREDICT});
        script.push_back('{16'h0001, 32'h7FFF_FFFE, ROW_PREDICT});
        // Fill every cell ahead, then release the whole window at once.
        for (int k = 5; k < 20; k++) begin
            script.push_back('{t_id'(k), 32'h0F0F_0000 | 32'(k), ROW_PREDICT});
        end
        script.push_back('{16'h0004, 32'hF0F0_0004, ROW_PREDICT});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) send_request(script[k].id, script[k].pay, script[k].kind);
        wait_for_drain();

        random_phase(80);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule : testbench
`default_nettype wire
